@@ design/id3v2_title_artist_extractor_top_defines.svh @@
// Assertion macros shared by the checker of the ID3v2 title/artist extractor.
// Depends on nothing; the including scope provides clk_i and rst_ni.
`ifndef ID3V2_TITLE_ARTIST_EXTRACTOR_TOP_DEFINES_SVH
`define ID3V2_TITLE_ARTIST_EXTRACTOR_TOP_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ID3TAE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("id3tae: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define ID3TAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("id3tae: next-cycle check failed");

`endif

@@ design/id3tae_pkg.sv @@
// Shared types and constants of the ID3v2 title/artist extractor.
// Used by the parser, the output buffer, the top level and the checker.
package id3tae_pkg;

  // Request payload: one raw tag byte
  typedef struct packed {
    logic [7:0] tag_byte;
    logic       start_of_tag;
  } in_item_t;

  // Result payload: one classified byte
  typedef struct packed {
    logic [1:0] byte_kind;
    logic [7:0] text_byte;
    logic       last_in_field;
    logic [1:0] parse_status;
    logic [7:0] tag_version;
  } out_item_t;

  // Byte kinds
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_TITLE  = 2'd1;
  localparam logic [1:0] KIND_ARTIST = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Parse status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_VER   = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  // Frame identifiers (v2.2 ids are three bytes)
  localparam logic [31:0] ID_TITLE_OLD  = 32'h0054_5432;  // TT2
  localparam logic [31:0] ID_ARTIST_OLD = 32'h0054_5031;  // TP1
  localparam logic [31:0] ID_TITLE_NEW  = 32'h5449_5432;  // TIT2
  localparam logic [31:0] ID_ARTIST_NEW = 32'h5450_4531;  // TPE1

  // Header flag bits
  localparam int unsigned FLAG_EXTHDR_BIT = 6;
  localparam int unsigned FLAG_FOOTER_BIT = 4;

  // Header and frame header lengths
  localparam logic [3:0] TAG_HDR_LAST  = 4'd9;
  localparam logic [3:0] EXT_SIZE_LEN  = 4'd4;
  localparam logic [3:0] EXT_HDR_LEN   = 4'd6;
  localparam logic [3:0] FHDR_LEN_OLD  = 4'd6;
  localparam logic [3:0] FHDR_LEN_NEW  = 4'd10;
  localparam logic [3:0] ID_LEN_OLD    = 4'd3;
  localparam logic [3:0] ID_LEN_NEW    = 4'd4;
  localparam logic [4:0] FOOTER_LEN    = 5'd10;

  // Versions
  localparam logic [7:0] VER_FIRST_NEW = 8'd3;
  localparam logic [7:0] VER_SYNCHSAFE = 8'd4;

endpackage

@@ design/id3v2_title_artist_extractor_top.sv @@
// Top level of the ID3v2 title/artist extractor: input register, parser, result register.
// Depends on id3tae_pkg, id3tae_parse and id3tae_obuf.

// Feed the tag one byte per request, with start_of_tag set on header byte 0;
// every byte gives exactly one result, in order. A byte is taken in every
// cycle while results are being taken, and a byte's result passes from the
// input register through the parser's combinational decode into the result
// register. Results name title and artist text bytes, mark the end of each
// field and the final byte of the tag, and carry the header's major version
// and the parse status.
module id3v2_title_artist_extractor_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  id3tae_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output id3tae_pkg::out_item_t out_data_o
);

  logic                  in_valid_q;
  id3tae_pkg::in_item_t  in_data_q;
  logic                  space;
  logic                  advance;
  logic                  accept;
  id3tae_pkg::out_item_t result;

  // Move the held byte into the parser when the result register has room
  assign advance    = in_valid_q && space;
  assign in_stall_o = in_valid_q && !space;
  assign accept     = in_valid_i && !in_stall_o;

  // Hold the input byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
  end

  id3tae_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_data_q),
    .result_o (result)
  );

  id3tae_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .data_i      (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ design/id3tae_parse.sv @@
// Tag parser state and per-byte decode of the ID3v2 title/artist extractor.
// Depends on id3tae_pkg for payload types, byte kinds and frame ids.
module id3tae_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  id3tae_pkg::in_item_t  item_i,
  output id3tae_pkg::out_item_t result_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_EXTHDR,
    PH_EXTSKIP,
    PH_FRAMEHDR,
    PH_TEXT,
    PH_FRAMESKIP,
    PH_SKIPREST
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  flags_q, flags_d;
  logic [27:0] rem_q, rem_d;       // tag bytes still to come
  logic [31:0] fid_q, fid_d;
  logic [31:0] fsize_q, fsize_d;
  logic        found_t_q, found_t_d;
  logic        found_a_q, found_a_d;
  logic        text_end_q, text_end_d;
  logic [1:0]  status_q, status_d;

  logic [7:0]  b;
  logic        old_ver;
  logic [3:0]  id_len;
  logic [3:0]  fhdr_len;
  logic [4:0]  need;
  logic [1:0]  fk;
  logic [7:0]  first_id;
  logic        do_enter;
  logic        counted;
  logic [1:0]  kind;
  logic [7:0]  text;
  logic        last;

  // Map a frame id to title, artist or neither
  function automatic logic [1:0] frame_kind(input logic [7:0] ver, input logic [31:0] id);
    logic [1:0] k;
    k = id3tae_pkg::KIND_OTHER;
    if (ver < id3tae_pkg::VER_FIRST_NEW) begin
      if (id == id3tae_pkg::ID_TITLE_OLD) k = id3tae_pkg::KIND_TITLE;
      else if (id == id3tae_pkg::ID_ARTIST_OLD) k = id3tae_pkg::KIND_ARTIST;
    end else begin
      if (id == id3tae_pkg::ID_TITLE_NEW) k = id3tae_pkg::KIND_TITLE;
      else if (id == id3tae_pkg::ID_ARTIST_NEW) k = id3tae_pkg::KIND_ARTIST;
    end
    return k;
  endfunction

  // Version-dependent frame header layout
  assign b        = item_i.tag_byte;
  assign old_ver  = ver_q < id3tae_pkg::VER_FIRST_NEW;
  assign id_len   = old_ver ? id3tae_pkg::ID_LEN_OLD : id3tae_pkg::ID_LEN_NEW;
  assign fhdr_len = old_ver ? id3tae_pkg::FHDR_LEN_OLD : id3tae_pkg::FHDR_LEN_NEW;
  assign need     = {1'b0, fhdr_len} +
                    (((ver_q > id3tae_pkg::VER_FIRST_NEW) &&
                      flags_q[id3tae_pkg::FLAG_FOOTER_BIT]) ? id3tae_pkg::FOOTER_LEN : 5'd0);

  // Decode one byte against the current parse state
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    ver_d      = ver_q;
    flags_d    = flags_q;
    rem_d      = rem_q;
    fid_d      = fid_q;
    fsize_d    = fsize_q;
    found_t_d  = found_t_q;
    found_a_d  = found_a_q;
    text_end_d = text_end_q;
    status_d   = status_q;
    do_enter   = 1'b0;
    counted    = 1'b0;
    kind       = id3tae_pkg::KIND_OTHER;
    text       = 8'd0;
    last       = 1'b0;
    fk         = frame_kind(ver_q, fid_q);
    first_id   = 8'd0;

    // Restart on a start marker
    if (item_i.start_of_tag) begin
      phase_d    = PH_HEADER;
      cnt_d      = 4'd0;
      ver_d      = 8'd0;
      flags_d    = 8'd0;
      rem_d      = 28'd0;
      fid_d      = 32'd0;
      fsize_d    = 32'd0;
      found_t_d  = 1'b0;
      found_a_d  = 1'b0;
      text_end_d = 1'b0;
      status_d   = id3tae_pkg::STATUS_OK;
    end

    if (phase_d == PH_HEADER) begin
      // Collect version, flags and synchsafe tag size
      if (cnt_d == 4'd3) ver_d = b;
      else if (cnt_d == 4'd5) flags_d = b;
      else if (cnt_d >= 4'd6) rem_d = {rem_d[20:0], b[6:0]};
      if (cnt_d >= id3tae_pkg::TAG_HDR_LAST) begin
        cnt_d   = 4'd0;
        counted = 1'b1;
        if (ver_d > id3tae_pkg::VER_SYNCHSAFE) begin
          status_d = id3tae_pkg::STATUS_BAD_VER;
          phase_d  = PH_SKIPREST;
        end else if ((ver_d >= id3tae_pkg::VER_FIRST_NEW) &&
                     flags_d[id3tae_pkg::FLAG_EXTHDR_BIT]) begin
          phase_d = PH_EXTHDR;
          fsize_d = 32'd0;
        end else begin
          do_enter = 1'b1;
        end
      end else begin
        cnt_d = cnt_d + 4'd1;
      end
    end else if (phase_d != PH_IDLE) begin
      counted = 1'b1;
      rem_d   = rem_q - 28'd1;
      unique case (phase_d) inside
        PH_EXTHDR: begin
          // Take the 28-bit extended header size, then skip its body
          if (cnt_d < id3tae_pkg::EXT_SIZE_LEN) fsize_d = {4'd0, fsize_d[20:0], b[6:0]};
          cnt_d = cnt_d + 4'd1;
          if (cnt_d >= id3tae_pkg::EXT_HDR_LEN) begin
            cnt_d = 4'd0;
            if (fsize_d > 32'({id3tae_pkg::EXT_HDR_LEN})) begin
              fsize_d = fsize_d - 32'({id3tae_pkg::EXT_HDR_LEN});
              phase_d = PH_EXTSKIP;
            end else begin
              do_enter = 1'b1;
            end
          end
        end
        PH_EXTSKIP, PH_FRAMESKIP: begin
          if (fsize_d != 32'd0) fsize_d = fsize_d - 32'd1;
          if (fsize_d == 32'd0) do_enter = 1'b1;
        end
        PH_FRAMEHDR: begin
          // Shift in id bytes, then size bytes
          if (cnt_d < id_len) fid_d = {fid_d[23:0], b};
          else if (ver_q == id3tae_pkg::VER_SYNCHSAFE) fsize_d = {fsize_d[24:0], b[6:0]};
          else fsize_d = {fsize_d[23:0], b};
          cnt_d = cnt_d + 4'd1;
          if (cnt_d >= fhdr_len) begin
            cnt_d    = 4'd0;
            first_id = old_ver ? fid_d[23:16] : fid_d[31:24];
            fk       = frame_kind(ver_q, fid_d);
            if (first_id == 8'd0) begin
              phase_d = PH_SKIPREST;
            end else if (fsize_d > {4'd0, rem_d}) begin
              status_d = id3tae_pkg::STATUS_TOO_LARGE;
              phase_d  = PH_SKIPREST;
            end else begin
              if (fk == id3tae_pkg::KIND_TITLE) found_t_d = 1'b1;
              if (fk == id3tae_pkg::KIND_ARTIST) found_a_d = 1'b1;
              text_end_d = 1'b0;
              phase_d    = (fk != id3tae_pkg::KIND_OTHER) ? PH_TEXT : PH_FRAMESKIP;
              if (fsize_d == 32'd0) do_enter = 1'b1;
            end
          end
        end
        PH_TEXT: begin
          // Drop the encoding byte, emit text up to the first zero
          if (fsize_d != 32'd0) fsize_d = fsize_d - 32'd1;
          if (cnt_d == 4'd0) begin
            cnt_d = 4'd1;
          end else if (!text_end_d) begin
            kind = fk;
            if (b == 8'd0) begin
              text_end_d = 1'b1;
              last       = 1'b1;
            end else begin
              text = b;
              last = (fsize_d == 32'd0);
            end
          end
          if (fsize_d == 32'd0) do_enter = 1'b1;
        end
        PH_IDLE, PH_HEADER, PH_SKIPREST: begin
        end
      endcase
    end

    // Open the next frame header or give up on the rest of the tag
    if (do_enter) begin
      if ((found_t_d && found_a_d) || ({23'd0, need} >= rem_d)) begin
        phase_d = PH_SKIPREST;
      end else begin
        phase_d = PH_FRAMEHDR;
        cnt_d   = 4'd0;
        fid_d   = 32'd0;
        fsize_d = 32'd0;
      end
    end

    // Close the tag on its final byte
    if (counted && (rem_d == 28'd0)) begin
      kind    = id3tae_pkg::KIND_END;
      phase_d = PH_IDLE;
    end
  end

  // Hold parse state; advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cnt_q      <= 4'd0;
      ver_q      <= 8'd0;
      flags_q    <= 8'd0;
      rem_q      <= 28'd0;
      fid_q      <= 32'd0;
      fsize_q    <= 32'd0;
      found_t_q  <= 1'b0;
      found_a_q  <= 1'b0;
      text_end_q <= 1'b0;
      status_q   <= id3tae_pkg::STATUS_OK;
    end else if (step_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      ver_q      <= ver_d;
      flags_q    <= flags_d;
      rem_q      <= rem_d;
      fid_q      <= fid_d;
      fsize_q    <= fsize_d;
      found_t_q  <= found_t_d;
      found_a_q  <= found_a_d;
      text_end_q <= text_end_d;
      status_q   <= status_d;
    end
  end

  // Assemble the result of this byte
  assign result_o.byte_kind     = kind;
  assign result_o.text_byte     = text;
  assign result_o.last_in_field = last;
  assign result_o.parse_status  = status_d;
  assign result_o.tag_version   = ver_d;

endmodule

@@ design/id3tae_obuf.sv @@
// Result register of the ID3v2 title/artist extractor with its handshake.
// Depends on id3tae_pkg for the result payload type.
module id3tae_obuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  id3tae_pkg::out_item_t data_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output id3tae_pkg::out_item_t out_data_o
);

  logic                  valid_q;
  id3tae_pkg::out_item_t data_q;

  // Free when empty or when the held result leaves this cycle
  assign space_o = !valid_q || !out_stall_i;

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ design/id3tae_chk.sv @@
// Port-level checker of the ID3v2 title/artist extractor, bound to its top level.
// Depends on id3tae_pkg and the assertion macros of the defines header.
`include "id3v2_title_artist_extractor_top_defines.svh"

module id3tae_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input id3tae_pkg::in_item_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input id3tae_pkg::out_item_t out_data_o
);

  // Keep a stalled result in place
  `ID3TAE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `ID3TAE_ASSERT_NEXT(a_data_hold, out_valid_o && out_stall_i, $stable(out_data_o))

  // Skipped bytes carry no text
  `ID3TAE_ASSERT_IMP(a_other_clean, out_valid_o && out_data_o.byte_kind == id3tae_pkg::KIND_OTHER, out_data_o.text_byte == 8'd0 && !out_data_o.last_in_field)

  // A zero inside text is the end mark of its field
  `ID3TAE_ASSERT_IMP(a_zero_ends, out_valid_o && (out_data_o.byte_kind == id3tae_pkg::KIND_TITLE || out_data_o.byte_kind == id3tae_pkg::KIND_ARTIST) && out_data_o.text_byte == 8'd0, out_data_o.last_in_field)

  // Status is always a defined code
  `ID3TAE_ASSERT_IMP(a_status_code, out_valid_o, out_data_o.parse_status == id3tae_pkg::STATUS_OK || out_data_o.parse_status == id3tae_pkg::STATUS_BAD_VER || out_data_o.parse_status == id3tae_pkg::STATUS_TOO_LARGE)

endmodule

bind id3v2_title_artist_extractor_top id3tae_chk u_chk (.*);

@@ tb/sv/tb_id3v2_title_artist_extractor_top.sv @@
// Testbench of the ID3v2 title/artist extractor: random and directed tag streams,
// checked byte by byte against a built-in parser model. Depends on id3tae_pkg.
`timescale 1ns / 100ps

module tb_id3v2_title_artist_extractor_top;

  // Parser phases of the prediction model
  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_EXTHDR, PH_EXTSKIP,
    PH_FRAMEHDR, PH_TEXT, PH_FRAMESKIP, PH_SKIPREST
  } parse_phase_e;

  // Track parser state, predict one result per request, compare results
  class tag_scoreboard;
    parse_phase_e          phase;
    logic [3:0]            byte_cnt;
    logic [7:0]            version;
    logic [7:0]            flags;
    logic [27:0]           tag_len;
    logic [28:0]           tag_pos;
    logic [31:0]           frame_id;
    logic [31:0]           size_acc;
    logic                  got_title;
    logic                  got_artist;
    logic                  text_done;
    logic [1:0]            status;
    id3tae_pkg::out_item_t expected_bytes[$];
    int unsigned           errors;
    int unsigned           title_bytes;
    int unsigned           artist_bytes;
    int unsigned           tag_ends;

    function new();
      clear();
      errors = 0;
      title_bytes = 0;
      artist_bytes = 0;
      tag_ends = 0;
    endfunction

    function void clear();
      phase = PH_IDLE;
      byte_cnt = '0;
      version = '0;
      flags = '0;
      tag_len = '0;
      tag_pos = '0;
      frame_id = '0;
      size_acc = '0;
      got_title = 1'b0;
      got_artist = 1'b0;
      text_done = 1'b0;
      status = id3tae_pkg::STATUS_OK;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [3:0] hdr_len();
      return (version < id3tae_pkg::VER_FIRST_NEW) ? id3tae_pkg::FHDR_LEN_OLD
                                                   : id3tae_pkg::FHDR_LEN_NEW;
    endfunction

    function logic [3:0] id_len();
      return (version < id3tae_pkg::VER_FIRST_NEW) ? id3tae_pkg::ID_LEN_OLD
                                                   : id3tae_pkg::ID_LEN_NEW;
    endfunction

    function logic [1:0] frame_kind();
      if (version < id3tae_pkg::VER_FIRST_NEW) begin
        if (frame_id == id3tae_pkg::ID_TITLE_OLD) return id3tae_pkg::KIND_TITLE;
        if (frame_id == id3tae_pkg::ID_ARTIST_OLD) return id3tae_pkg::KIND_ARTIST;
      end else begin
        if (frame_id == id3tae_pkg::ID_TITLE_NEW) return id3tae_pkg::KIND_TITLE;
        if (frame_id == id3tae_pkg::ID_ARTIST_NEW) return id3tae_pkg::KIND_ARTIST;
      end
      return id3tae_pkg::KIND_OTHER;
    endfunction

    // Start the next frame header, or skip the rest of the tag
    function void enter_frames();
      logic [31:0] need;
      need = 32'(tag_pos) + 32'(hdr_len());
      if (version > id3tae_pkg::VER_FIRST_NEW && flags[id3tae_pkg::FLAG_FOOTER_BIT]) begin
        need += 32'(id3tae_pkg::FOOTER_LEN);
      end
      if ((got_title && got_artist) || need >= 32'(tag_len)) begin
        phase = PH_SKIPREST;
        return;
      end
      phase = PH_FRAMEHDR;
      byte_cnt = '0;
      frame_id = '0;
      size_acc = '0;
    endfunction

    // Advance the model by one accepted request and queue its result
    function void note_request(id3tae_pkg::in_item_t req);
      logic [7:0]            b;
      logic [3:0]            i;
      logic [1:0]            fk;
      logic [7:0]            first;
      id3tae_pkg::out_item_t res;
      b = req.tag_byte;
      res = '0;
      if (req.start_of_tag) begin
        clear();
        phase = PH_HEADER;
      end
      if (phase == PH_HEADER) begin
        i = byte_cnt;
        if (i == 4'd3) version = b;
        else if (i == 4'd5) flags = b;
        else if (i >= 4'd6) tag_len = {tag_len[20:0], b[6:0]};
        byte_cnt = i + 4'd1;
        if (i >= id3tae_pkg::TAG_HDR_LAST) begin
          byte_cnt = '0;
          tag_pos = '0;
          if (version > id3tae_pkg::VER_SYNCHSAFE) begin
            status = id3tae_pkg::STATUS_BAD_VER;
            phase = PH_SKIPREST;
          end else if (version >= id3tae_pkg::VER_FIRST_NEW &&
                       flags[id3tae_pkg::FLAG_EXTHDR_BIT]) begin
            phase = PH_EXTHDR;
            size_acc = '0;
          end else begin
            enter_frames();
          end
          if (tag_len == '0) begin
            res.byte_kind = id3tae_pkg::KIND_END;
            phase = PH_IDLE;
          end
        end
      end else if (phase != PH_IDLE) begin
        tag_pos = tag_pos + 29'd1;
        case (phase)
          PH_EXTHDR: begin
            if (byte_cnt < id3tae_pkg::EXT_SIZE_LEN) begin
              size_acc = {4'd0, size_acc[20:0], b[6:0]};
            end
            byte_cnt = byte_cnt + 4'd1;
            if (byte_cnt >= id3tae_pkg::EXT_HDR_LEN) begin
              byte_cnt = '0;
              if (size_acc > 32'd6) begin
                size_acc -= 32'd6;
                phase = PH_EXTSKIP;
              end else begin
                enter_frames();
              end
            end
          end
          PH_EXTSKIP, PH_FRAMESKIP: begin
            if (size_acc > 0) size_acc--;
            if (size_acc == 0) enter_frames();
          end
          PH_FRAMEHDR: begin
            i = byte_cnt;
            if (i < id_len()) frame_id = {frame_id[23:0], b};
            else if (version == id3tae_pkg::VER_SYNCHSAFE) size_acc = {size_acc[24:0], b[6:0]};
            else size_acc = {size_acc[23:0], b};
            byte_cnt = i + 4'd1;
            if (byte_cnt >= hdr_len()) begin
              first = (id_len() == id3tae_pkg::ID_LEN_OLD) ? frame_id[23:16] : frame_id[31:24];
              byte_cnt = '0;
              if (first == 8'd0) begin
                // padding ends the frame walk
                phase = PH_SKIPREST;
              end else if (32'(tag_pos) > 32'(tag_len) ||
                           size_acc > 32'(tag_len) - 32'(tag_pos)) begin
                status = id3tae_pkg::STATUS_TOO_LARGE;
                phase = PH_SKIPREST;
              end else begin
                fk = frame_kind();
                if (fk == id3tae_pkg::KIND_TITLE) got_title = 1'b1;
                if (fk == id3tae_pkg::KIND_ARTIST) got_artist = 1'b1;
                text_done = 1'b0;
                phase = (fk != id3tae_pkg::KIND_OTHER) ? PH_TEXT : PH_FRAMESKIP;
                if (size_acc == 0) enter_frames();
              end
            end
          end
          PH_TEXT: begin
            fk = frame_kind();
            if (size_acc > 0) size_acc--;
            if (byte_cnt == '0) begin
              // drop the encoding byte
              byte_cnt = 4'd1;
            end else if (!text_done) begin
              res.byte_kind = fk;
              if (b == 8'd0) begin
                text_done = 1'b1;
                res.last_in_field = 1'b1;
              end else begin
                res.text_byte = b;
                res.last_in_field = (size_acc == 0);
              end
            end
            if (size_acc == 0) enter_frames();
          end
          default: ;
        endcase
        if (32'(tag_pos) >= 32'(tag_len)) begin
          res.byte_kind = id3tae_pkg::KIND_END;
          phase = PH_IDLE;
        end
      end
      res.parse_status = status;
      res.tag_version = version;
      expected_bytes.push_back(res);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(id3tae_pkg::out_item_t got);
      id3tae_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("result with no pending request: %h", got);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.byte_kind !== want.byte_kind) begin
        $error("byte_kind: expected %0d, actual %0d", want.byte_kind, got.byte_kind);
        errors++;
      end
      if (got.text_byte !== want.text_byte) begin
        $error("text_byte: expected %h, actual %h", want.text_byte, got.text_byte);
        errors++;
      end
      if (got.last_in_field !== want.last_in_field) begin
        $error("last_in_field: expected %0d, actual %0d", want.last_in_field,
               got.last_in_field);
        errors++;
      end
      if (got.parse_status !== want.parse_status) begin
        $error("parse_status: expected %0d, actual %0d", want.parse_status,
               got.parse_status);
        errors++;
      end
      if (got.tag_version !== want.tag_version) begin
        $error("tag_version: expected %h, actual %h", want.tag_version, got.tag_version);
        errors++;
      end
      if (want.byte_kind == id3tae_pkg::KIND_TITLE) title_bytes++;
      if (want.byte_kind == id3tae_pkg::KIND_ARTIST) artist_bytes++;
      if (want.byte_kind == id3tae_pkg::KIND_END) tag_ends++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  id3tae_pkg::in_item_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  id3tae_pkg::out_item_t out_data_o;

  tag_scoreboard sb = new();
  logic [7:0]    tag_stream[$];
  logic          tx_calm = 1'b0;
  logic          rx_calm = 1'b0;
  int unsigned   tag_items = 0;
  int unsigned   tag_count = 0;

  id3v2_title_artist_extractor_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Gap length: mostly short, a few long
  function automatic int pick_gap(logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: stall at random in held stretches
  initial begin : rx_stall_gen
    int   hold;
    logic stall_now;
    hold = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (rx_calm || $urandom_range(0, 1) == 0) begin
        stall_now = 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        stall_now = 1'b1;
        hold = pick_gap(1'b0);
      end
      out_stall_i <= stall_now;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Offer one byte, hold it until accepted, then log the request
  task automatic send_tag_byte(logic [7:0] b, logic sot);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{tag_byte: b, start_of_tag: sot};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(in_data_i);
  endtask

  // Send the first cut bytes of the built stream as one tag
  task automatic send_stream(int cut);
    for (int i = 0; i < cut; i++) begin
      send_tag_byte(tag_stream[i], i == 0);
      tag_items++;
    end
    tag_count++;
  endtask

  // Hold the sender until every result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Append a synchsafe value with random bit 7 in every byte
  function automatic void push_synchsafe(logic [27:0] v);
    for (int k = 3; k >= 0; k--) tag_stream.push_back({1'($urandom_range(0, 3) == 0), v[7*k +: 7]});
  endfunction

  // Build one random tag: header, optional extended header, frames, padding, footer
  function automatic void build_tag();
    logic [7:0]  ver;
    logic [7:0]  flg;
    logic [31:0] fid;
    logic [31:0] fsize;
    logic [27:0] tlen;
    int          r;
    int          ext_sz;
    int          nfr;
    int          dlen;
    int          body_len;
    int          extra;
    tag_stream.delete();
    r = $urandom_range(0, 19);
    if (r < 5) ver = 8'd2;
    else if (r < 10) ver = 8'd3;
    else if (r < 16) ver = 8'd4;
    else if (r == 16) ver = 8'($urandom_range(0, 1));
    else ver = 8'($urandom_range(5, 255));
    flg = 8'($urandom_range(0, 255));
    flg[id3tae_pkg::FLAG_EXTHDR_BIT] = ($urandom_range(0, 3) == 0);
    flg[id3tae_pkg::FLAG_FOOTER_BIT] = ($urandom_range(0, 2) == 0);
    // header; magic is not checked, so sometimes garble it
    if ($urandom_range(0, 9) == 0) begin
      repeat (3) tag_stream.push_back(8'($urandom_range(0, 255)));
    end else begin
      tag_stream.push_back(8'h49);
      tag_stream.push_back(8'h44);
      tag_stream.push_back(8'h33);
    end
    tag_stream.push_back(ver);
    tag_stream.push_back(8'($urandom_range(0, 255)));
    tag_stream.push_back(flg);
    repeat (4) tag_stream.push_back(8'h00);
    if (ver >= id3tae_pkg::VER_FIRST_NEW && flg[id3tae_pkg::FLAG_EXTHDR_BIT]) begin
      ext_sz = $urandom_range(0, 12);
      push_synchsafe(28'(ext_sz));
      repeat (2) tag_stream.push_back(8'($urandom_range(0, 255)));
      if (ext_sz > 6) repeat (ext_sz - 6) tag_stream.push_back(8'($urandom_range(0, 255)));
    end
    nfr = $urandom_range(0, 4);
    for (int f = 0; f < nfr; f++) begin
      r = $urandom_range(0, 9);
      if (ver < id3tae_pkg::VER_FIRST_NEW) begin
        if (r < 4) fid = id3tae_pkg::ID_TITLE_OLD;
        else if (r < 8) fid = id3tae_pkg::ID_ARTIST_OLD;
        else fid = {8'h00, 8'($urandom_range(1, 255)), 16'($urandom())};
      end else begin
        if (r < 4) fid = id3tae_pkg::ID_TITLE_NEW;
        else if (r < 8) fid = id3tae_pkg::ID_ARTIST_NEW;
        else fid = {8'($urandom_range(1, 255)), 24'($urandom())};
      end
      dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      fsize = 32'(dlen);
      if ($urandom_range(0, 15) == 0) begin
        fsize = ($urandom_range(0, 1) == 0) ? 32'(dlen + $urandom_range(1, 64)) : $urandom();
      end
      if (ver < id3tae_pkg::VER_FIRST_NEW) begin
        for (int k = 2; k >= 0; k--) tag_stream.push_back(fid[8*k +: 8]);
        for (int k = 2; k >= 0; k--) tag_stream.push_back(fsize[8*k +: 8]);
      end else begin
        for (int k = 3; k >= 0; k--) tag_stream.push_back(fid[8*k +: 8]);
        if (ver == id3tae_pkg::VER_SYNCHSAFE) push_synchsafe(fsize[27:0]);
        else for (int k = 3; k >= 0; k--) tag_stream.push_back(fsize[8*k +: 8]);
        repeat (2) tag_stream.push_back(8'($urandom_range(0, 255)));
      end
      if (dlen > 0) tag_stream.push_back(8'($urandom_range(0, 3)));
      for (int k = 1; k < dlen; k++) begin
        tag_stream.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) tag_stream.push_back(8'h00);
    if (ver == id3tae_pkg::VER_SYNCHSAFE && flg[id3tae_pkg::FLAG_FOOTER_BIT]) begin
      repeat (10) tag_stream.push_back(8'($urandom_range(0, 255)));
    end
    // tag size: mostly exact, sometimes short, long or huge
    body_len = tag_stream.size() - 10;
    r = $urandom_range(0, 19);
    if (r < 2 && body_len > 0) begin
      tlen = 28'(body_len - $urandom_range(1, body_len));
    end else if (r < 4) begin
      extra = $urandom_range(1, 8);
      tlen = 28'(body_len + extra);
      repeat (extra) tag_stream.push_back(8'($urandom_range(0, 255)));
    end else if (r == 4) begin
      tlen = ($urandom_range(0, 1) == 0) ? 28'hFFF_FFFF : 28'($urandom());
    end else begin
      tlen = 28'(body_len);
    end
    for (int k = 0; k < 4; k++) begin
      tag_stream[6 + k] = {1'($urandom_range(0, 3) == 0), tlen[7*(3-k) +: 7]};
    end
  endfunction

  // Main stimulus
  initial begin : stimulus
    int r;
    int cut;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle byte, zero-size tag with bit 7 set in all size bytes,
    // unsupported version, then a restart in the middle of a header
    send_tag_byte(8'hFF, 1'b0);
    tag_stream = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80};
    send_stream(10);
    tag_stream = '{8'h49, 8'h44, 8'h33, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
                   8'hFF, 8'h00};
    send_stream(12);
    tag_stream = '{8'h49, 8'h44, 8'h33};
    send_stream(3);
    drain_results();

    // random tags with noise, cut streams and idle bytes between them
    while (tag_items < 800) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 29);
      if (r == 0) begin
        repeat ($urandom_range(5, 20)) begin
          send_tag_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end else begin
        build_tag();
        cut = tag_stream.size();
        if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, tag_stream.size());
        send_stream(cut);
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) send_tag_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if (tag_count == 5 || $urandom_range(0, 9) == 0) drain_results();
    end

    // wait out the remaining results and let the clock run on before the report
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d tags over %0d tag bytes: %0d title and %0d artist text bytes,",
             tag_count, tag_items, sb.title_bytes, sb.artist_bytes);
    $display("%0d tag ends, %0d mismatches.", sb.tag_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
